// ----- rtl/rspt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the range sign product tree: sizes, sign codes, queue item type,
// engine states and the sign product function. No dependencies.
package rspt_pkg;

    localparam int LEAVES  = 1024;
    localparam int LVL     = $clog2(LEAVES);
    localparam int SPAN    = 1 << LVL;
    localparam int NODES   = 2 * SPAN;
    localparam int NODE_W  = LVL + 1;
    localparam int LOHI_W  = LVL + 2;
    localparam int POS_W   = 11;
    localparam int VAL_W   = 32;
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    typedef logic signed [1:0] t_sign;

    localparam t_sign SIGN_POS  = 2'sb01;
    localparam t_sign SIGN_ZERO = 2'sb00;
    localparam t_sign SIGN_NEG  = 2'sb11;

    localparam logic REQ_CHANGE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // For a change, lo carries the leaf node; for a query, [lo, hi) is the
    // half-open node range on the leaf row.
    typedef struct packed {
        logic              kind;
        logic [LOHI_W-1:0] lo;
        logic [LOHI_W-1:0] hi;
        t_sign             sgn;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_C_WR,
        ST_C_CALC,
        ST_Q_CHK,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_OUT
    } t_state;

    function automatic t_sign sign_mul(input t_sign a, input t_sign b);
        t_sign r;
        if (a == SIGN_ZERO || b == SIGN_ZERO) begin
            r = SIGN_ZERO;
        end else if (a == b) begin
            r = SIGN_POS;
        end else begin
            r = SIGN_NEG;
        end
        return r;
    endfunction

endpackage

// ----- rtl/rspt_if.sv -----
`timescale 1ns / 1ps
// Request and result channel interfaces of the range sign product tree.
// Depends on rspt_pkg.
interface rspt_req_if;
    import rspt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        range_left;
    logic [POS_W-1:0]        range_right;

    modport source(output valid, req_type, position, value, range_left, range_right,
                   input ready);
    modport sink(input valid, req_type, position, value, range_left, range_right,
                 output ready);
endinterface

interface rspt_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] product_sign;

    modport source(output valid, product_sign, input ready);
    modport sink(input valid, product_sign, output ready);
endinterface

// ----- rtl/range_sign_product_tree_core.sv -----
`timescale 1ns / 1ps
// Range sign product tree. i_req carries requests: req_type 0 stores the sign
// of value at a 1-based position (no result), req_type 1 asks for the sign of
// the product over range_left..range_right (one result on o_rsp, -1, 0 or +1).
// Out-of-range changes are dropped; query ranges are clipped to the positions,
// and an empty range gives +1. Both channels use valid/ready.
// For a change the engine walks the ancestors of the leaf: at each level it
// writes the node and reads its sibling (ST_C_WR), then forms the parent
// product (ST_C_CALC). A query starts in ST_IDLE; at each tree level that
// the range still covers, ST_Q_CHK checks the bounds, ST_Q_LO and ST_Q_HI
// take in each boundary node read through the single read port of the tree
// memory, and the bounds move up a level; ST_Q_OUT then loads the result
// register. One request is worked on at a time; a four-deep queue lets the
// front accept new requests meanwhile. After reset a clearing pass sets all
// 2048 nodes to +1, during which i_req.ready stays low. If the receiver
// stalls, the result register holds the result and the engine waits before
// the next one.
// Depends on rspt_pkg, rspt_if, rspt_front, rspt_queue and rspt_back.
module range_sign_product_tree_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rspt_req_if.sink   i_req,
    rspt_rsp_if.source o_rsp
);
    import rspt_pkg::*;

    logic  push;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    logic  clearing;
    t_item f_item;
    t_item q_item;

    rspt_front u_front (
        .i_req      (i_req),
        .i_clearing (clearing),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_item     (f_item)
    );

    rspt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    rspt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (pop),
        .o_clearing   (clearing),
        .o_rsp        (o_rsp)
    );
endmodule

// ----- rtl/rspt_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rspt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rspt_front.sv -----
`timescale 1ns / 1ps
// Front end: takes requests, reduces values to signs, clips query ranges and
// maps positions to tree nodes. Drops out-of-range changes. Depends on rspt_pkg.
module rspt_front (
    rspt_req_if.sink        i_req,
    input  logic            i_clearing,
    input  logic            i_q_ready,
    output logic            o_push,
    output rspt_pkg::t_item o_item
);
    import rspt_pkg::*;

    localparam logic [POS_W-1:0]  LAST_POS = POS_W'(LEAVES);
    localparam logic [LOHI_W-1:0] SPAN_N   = LOHI_W'(SPAN);

    logic [POS_W-1:0] left_c;
    logic [POS_W-1:0] right_c;
    logic             pos_ok;
    t_sign            sgn;

    assign i_req.ready = !i_clearing && i_q_ready;

    always_comb begin
        left_c  = (i_req.range_left == '0) ? POS_W'(1) : i_req.range_left;
        right_c = (i_req.range_right > LAST_POS) ? LAST_POS : i_req.range_right;
        pos_ok  = (i_req.position != '0) && (i_req.position <= LAST_POS);

        if (i_req.value == '0) begin
            sgn = SIGN_ZERO;
        end else if (i_req.value[VAL_W-1]) begin
            sgn = SIGN_NEG;
        end else begin
            sgn = SIGN_POS;
        end

        o_item.kind = i_req.req_type;
        o_item.sgn  = sgn;
        if (i_req.req_type == REQ_CHANGE) begin
            o_item.lo = SPAN_N + LOHI_W'(i_req.position) - LOHI_W'(1);
            o_item.hi = SPAN_N;
        end else if (left_c > right_c) begin
            // An empty range leaves nothing to walk and yields +1.
            o_item.lo = SPAN_N;
            o_item.hi = SPAN_N;
        end else begin
            o_item.lo = SPAN_N + LOHI_W'(left_c) - LOHI_W'(1);
            o_item.hi = SPAN_N + LOHI_W'(right_c);
        end

        o_push = i_req.valid && i_req.ready && (i_req.req_type == REQ_QUERY || pos_ok);
    end
endmodule

// ----- rtl/rspt_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of classified requests between the front end and the tree engine.
// Depends on rspt_pkg.
module rspt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rspt_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output rspt_pkg::t_item o_item,
    input  logic            i_pop
);
    import rspt_pkg::*;

    t_item            r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr_ptr;
    logic [QA_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;
    logic [QA_W-1:0]  n_wr_ptr;
    logic [QA_W-1:0]  n_rd_ptr;
    logic [QC_W-1:0]  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QA_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QA_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QC_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule

// ----- rtl/rspt_back.sv -----
`timescale 1ns / 1ps
// Tree engine: clears the sign tree after reset, walks ancestors for changes,
// walks the range for queries and holds the result register.
// Depends on rspt_pkg, rspt_if and rspt_ram.
module rspt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  rspt_pkg::t_item i_item,
    output logic            o_item_pop,
    output logic            o_clearing,
    rspt_rsp_if.source      o_rsp
);
    import rspt_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [NODE_W-1:0] r_clr_cnt;
    logic [NODE_W-1:0] n_clr_cnt;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] n_node;
    t_sign             r_val;
    t_sign             n_val;
    logic [LOHI_W-1:0] r_lo;
    logic [LOHI_W-1:0] n_lo;
    logic [LOHI_W-1:0] r_hi;
    logic [LOHI_W-1:0] n_hi;
    logic [LOHI_W-1:0] lo_inc;
    logic [LOHI_W-1:0] hi_dec;
    t_sign             r_acc;
    t_sign             n_acc;
    logic              r_out_valid;
    t_sign             r_out_sign;
    logic              out_load;

    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [1:0]        ram_wdata;
    logic [NODE_W-1:0] ram_raddr;
    logic [1:0]        ram_rdata;
    t_sign             rd_sign;

    rspt_ram #(
        .WIDTH (2),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_sign = t_sign'(ram_rdata);
    assign lo_inc  = r_lo + LOHI_W'(1);
    assign hi_dec  = r_hi - LOHI_W'(1);

    assign o_clearing       = (r_state == ST_CLEAR);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.product_sign = r_out_sign;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == NODE_W'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = (i_item.kind == REQ_CHANGE) ? ST_C_WR : ST_Q_CHK;
                end
            end
            ST_C_WR: begin
                n_state = (r_node == NODE_W'(1)) ? ST_IDLE : ST_C_CALC;
            end
            ST_C_CALC: begin
                n_state = ST_C_WR;
            end
            ST_Q_CHK: begin
                if (r_lo >= r_hi) begin
                    n_state = ST_Q_OUT;
                end else if (r_lo[0]) begin
                    n_state = ST_Q_LO;
                end else if (r_hi[0]) begin
                    n_state = ST_Q_HI;
                end
            end
            ST_Q_LO: begin
                n_state = r_hi[0] ? ST_Q_HI : ST_Q_CHK;
            end
            ST_Q_HI: begin
                n_state = ST_Q_CHK;
            end
            ST_Q_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        n_clr_cnt  = r_clr_cnt;
        n_node     = r_node;
        n_val      = r_val;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_acc      = r_acc;
        o_item_pop = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_node;
        ram_wdata  = r_val;
        ram_raddr  = r_lo[NODE_W-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = SIGN_POS;
                n_clr_cnt = r_clr_cnt + NODE_W'(1);
            end
            ST_IDLE: begin
                o_item_pop = i_item_valid;
                n_node     = i_item.lo[NODE_W-1:0];
                n_val      = i_item.sgn;
                n_lo       = i_item.lo;
                n_hi       = i_item.hi;
                n_acc      = SIGN_POS;
            end
            ST_C_WR: begin
                // Store this node and fetch its sibling for the parent product.
                ram_we    = 1'b1;
                ram_raddr = r_node ^ NODE_W'(1);
            end
            ST_C_CALC: begin
                n_val  = sign_mul(r_val, rd_sign);
                n_node = r_node >> 1;
            end
            ST_Q_CHK: begin
                if (r_lo >= r_hi) begin
                    n_acc = r_acc;
                end else if (r_lo[0]) begin
                    ram_raddr = r_lo[NODE_W-1:0];
                end else if (r_hi[0]) begin
                    ram_raddr = hi_dec[NODE_W-1:0];
                end else begin
                    n_lo = r_lo >> 1;
                    n_hi = r_hi >> 1;
                end
            end
            ST_Q_LO: begin
                n_acc = sign_mul(r_acc, rd_sign);
                if (r_hi[0]) begin
                    ram_raddr = hi_dec[NODE_W-1:0];
                    n_lo      = lo_inc;
                end else begin
                    n_lo = lo_inc >> 1;
                    n_hi = r_hi >> 1;
                end
            end
            ST_Q_HI: begin
                n_acc = sign_mul(r_acc, rd_sign);
                n_lo  = r_lo >> 1;
                n_hi  = hi_dec >> 1;
            end
            ST_Q_OUT: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                n_clr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_val  <= n_val;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_acc  <= n_acc;
        if (out_load) begin
            r_out_sign <= r_acc;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_item_pop)
        else $error("request taken during the clearing pass");

    a_calc_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C_CALC) |-> (r_node > NODE_W'(1)))
        else $error("ancestor walk went past the root");

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_CHK || r_state == ST_Q_LO || r_state == ST_Q_HI)
        |-> (r_lo <= r_hi))
        else $error("query walk bounds crossed");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_Q_OUT))
        else $error("result raised outside a finished query");

    a_no_tree_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_CHK || r_state == ST_Q_LO || r_state == ST_Q_HI) |-> !ram_we)
        else $error("tree written during a query");
`endif
endmodule
